>>> design/temporal_tv_gradient_defines.svh
// Assertion macros shared by the checker of the temporal TV gradient block.
// Plain text macros only; no dependencies.
`ifndef TEMPORAL_TV_GRADIENT_DEFINES_SVH
`define TEMPORAL_TV_GRADIENT_DEFINES_SVH

// same-cycle implication
`define TTVG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define TTVG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> design/ttvg_pkg.sv
// Types, constants and width helpers for the temporal TV gradient block.
// No dependencies.
package ttvg_pkg;

	localparam int CFG_WIDTH    = 31;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int FRAC_BITS    = 16;
	localparam int Q_BITS       = FRAC_BITS + 1;
	localparam int N_WIDTH      = FRAC_BITS + 2;
	localparam int COMB_LATENCY = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA_SQ = 2'd1;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] beta;
		logic [CFG_WIDTH-1:0] beta_sq;
	} ttvg_cfg_t;

	// width of |d|^2 + beta_sq in Q.32, always even
	function automatic int sum_width(int w);
		return (2 * w + 2 > CFG_WIDTH + FRAC_BITS + 1) ? 2 * w + 2 : CFG_WIDTH + FRAC_BITS + 1;
	endfunction

	function automatic int root_width(int w);
		return sum_width(w) / 2;
	endfunction

	// diff, square, two sums, root steps, divide steps, output
	function automatic int norm_latency(int w);
		return root_width(w) + Q_BITS + 5;
	endfunction

endpackage

>>> design/ttvg_if.sv
// Handshake channel interfaces: input item, result item, config write.
// Uses ttvg_pkg for config widths.
interface ttvg_in_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] cur_real;
	logic signed [W-1:0] cur_imag;
	logic signed [W-1:0] next_real;
	logic signed [W-1:0] next_imag;
	logic signed [W-1:0] prev_real;
	logic signed [W-1:0] prev_imag;
	logic signed [W-1:0] grad_in_real;
	logic signed [W-1:0] grad_in_imag;
	modport source (output valid, cur_real, cur_imag, next_real, next_imag, prev_real,
		prev_imag, grad_in_real, grad_in_imag, input ready);
	modport sink (input valid, cur_real, cur_imag, next_real, next_imag, prev_real,
		prev_imag, grad_in_real, grad_in_imag, output ready);
endinterface

interface ttvg_out_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] grad_out_real;
	logic signed [W-1:0] grad_out_imag;
	modport source (output valid, grad_out_real, grad_out_imag, input ready);
	modport sink (input valid, grad_out_real, grad_out_imag, output ready);
endinterface

interface ttvg_cfg_if;
	import ttvg_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/ttvg_norm.sv
// Pipelined normalizer: d = a - b, n = d / sqrt(|d|^2 + beta_sq) per component.
// Uses ttvg_pkg; split squares, one root bit per stage, one quotient bit per stage.
module ttvg_norm
	import ttvg_pkg::*;
#(
	parameter int W = 32
) (
	input  logic                      clk,
	input  logic                      en,
	input  ttvg_cfg_t                 cfg,
	input  logic signed [W-1:0]       a_real,
	input  logic signed [W-1:0]       a_imag,
	input  logic signed [W-1:0]       b_real,
	input  logic signed [W-1:0]       b_imag,
	output logic signed [N_WIDTH-1:0] n_real,
	output logic signed [N_WIDTH-1:0] n_imag
);

	localparam int DW  = W + 1;
	localparam int HW  = (DW + 1) / 2;
	localparam int LW  = DW - HW;
	localparam int SW  = sum_width(W);
	localparam int RW  = root_width(W);
	localparam int RMW = RW + 3;
	localparam int NW  = RW + Q_BITS;

	logic signed [DW-1:0] dr_s1, di_s1;
	logic [DW-1:0] mr, mi;
	logic [2*LW-1:0] rhh_s2, ihh_s2;
	logic [DW-1:0] rhl_s2, ihl_s2;
	logic [2*HW-1:0] rll_s2, ill_s2;
	logic [DW-1:0] mr_s2, mi_s2, mr_s3, mi_s3;
	logic [1:0] neg_s2, neg_s3;
	logic [SW-1:0] sqr_s3, sqi_s3;

	// sqrt pipe: index 0 is the sum stage, index k+1 follows root step k
	logic [SW-1:0]  sq_s [RW+1];
	logic [DW-1:0]  mr_s [RW+1];
	logic [DW-1:0]  mi_s [RW+1];
	logic [1:0]     neg_s [RW+1];
	logic [RMW-1:0] rem_s [RW];
	logic [RW-1:0]  root_s [RW];

	// divide pipe: index j follows quotient step j
	logic [NW-1:0]     numr_d [Q_BITS];
	logic [NW-1:0]     numi_d [Q_BITS];
	logic [Q_BITS-1:0] qr_d [Q_BITS];
	logic [Q_BITS-1:0] qi_d [Q_BITS];
	logic [RW-1:0]     rt_d [Q_BITS];
	logic [1:0]        neg_d [Q_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s1 <= DW'(a_real) - DW'(b_real);
			di_s1 <= DW'(a_imag) - DW'(b_imag);
		end
	end

	assign mr = dr_s1[DW-1] ? DW'(-dr_s1) : DW'(dr_s1);
	assign mi = di_s1[DW-1] ? DW'(-di_s1) : DW'(di_s1);

	// m^2 = h^2 << 2H + 2hl << H + l^2
	always_ff @(posedge clk) begin
		if (en) begin
			rhh_s2 <= mr[DW-1:HW] * mr[DW-1:HW];
			rhl_s2 <= mr[DW-1:HW] * mr[HW-1:0];
			rll_s2 <= mr[HW-1:0] * mr[HW-1:0];
			ihh_s2 <= mi[DW-1:HW] * mi[DW-1:HW];
			ihl_s2 <= mi[DW-1:HW] * mi[HW-1:0];
			ill_s2 <= mi[HW-1:0] * mi[HW-1:0];
			mr_s2  <= mr;
			mi_s2  <= mi;
			neg_s2 <= {di_s1[DW-1], dr_s1[DW-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqr_s3 <= (SW'(rhh_s2) << (2 * HW)) + (SW'(rhl_s2) << (HW + 1)) + SW'(rll_s2);
			sqi_s3 <= (SW'(ihh_s2) << (2 * HW)) + (SW'(ihl_s2) << (HW + 1)) + SW'(ill_s2);
			mr_s3  <= mr_s2;
			mi_s3  <= mi_s2;
			neg_s3 <= neg_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0]  <= sqr_s3 + sqi_s3 + (SW'(cfg.beta_sq) << FRAC_BITS);
			mr_s[0]  <= mr_s3;
			mi_s[0]  <= mi_s3;
			neg_s[0] <= neg_s3;
		end
	end

	for (genvar k = 0; k < RW; k++) begin : g_root
		logic [RMW-1:0] rem_in, rem_sh, trial;
		logic [RW-1:0]  root_in;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign rem_sh = {rem_in[RMW-3:0], sq_s[k][2*(RW-1-k)+1 -: 2]};
		assign trial  = RMW'({root_in, 2'b01});
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]    <= ge ? rem_sh - trial : rem_sh;
				root_s[k]   <= {root_in[RW-2:0], ge};
				mr_s[k+1]   <= mr_s[k];
				mi_s[k+1]   <= mi_s[k];
				neg_s[k+1]  <= neg_s[k];
				if (k < RW - 1)
					sq_s[k+1] <= sq_s[k];
			end
		end
	end

	for (genvar j = 0; j < Q_BITS; j++) begin : g_div
		localparam int B = Q_BITS - 1 - j;
		logic [NW-1:0]     nr_in, ni_in, t;
		logic [Q_BITS-1:0] qr_in, qi_in, qr_nx, qi_nx;
		logic [RW-1:0]     rt_in;
		logic [1:0]        neg_in;
		logic              ger, gei;

		if (j == 0) begin : g_first
			assign nr_in  = NW'({mr_s[RW], {FRAC_BITS{1'b0}}});
			assign ni_in  = NW'({mi_s[RW], {FRAC_BITS{1'b0}}});
			assign qr_in  = '0;
			assign qi_in  = '0;
			assign rt_in  = root_s[RW-1];
			assign neg_in = neg_s[RW];
		end else begin : g_next
			assign nr_in  = numr_d[j-1];
			assign ni_in  = numi_d[j-1];
			assign qr_in  = qr_d[j-1];
			assign qi_in  = qi_d[j-1];
			assign rt_in  = rt_d[j-1];
			assign neg_in = neg_d[j-1];
		end

		assign t   = NW'(rt_in) << B;
		assign ger = t <= nr_in;
		assign gei = t <= ni_in;

		always_comb begin
			qr_nx    = qr_in;
			qi_nx    = qi_in;
			qr_nx[B] = ger;
			qi_nx[B] = gei;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				numr_d[j] <= ger ? nr_in - t : nr_in;
				numi_d[j] <= gei ? ni_in - t : ni_in;
				qr_d[j]   <= qr_nx;
				qi_d[j]   <= qi_nx;
				rt_d[j]   <= rt_in;
				neg_d[j]  <= neg_in;
			end
		end
	end

	// a zero root means zero difference and zero beta_sq: n is zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (rt_d[Q_BITS-1] == '0) begin
				n_real <= '0;
				n_imag <= '0;
			end else begin
				n_real <= neg_d[Q_BITS-1][0] ? -$signed(N_WIDTH'(qr_d[Q_BITS-1]))
					: $signed(N_WIDTH'(qr_d[Q_BITS-1]));
				n_imag <= neg_d[Q_BITS-1][1] ? -$signed(N_WIDTH'(qi_d[Q_BITS-1]))
					: $signed(N_WIDTH'(qi_d[Q_BITS-1]));
			end
		end
	end

endmodule

>>> design/ttvg_comb.sv
// Combine stage: grad + round(beta * (n1 - n2)), saturated; four registers deep.
// Uses ttvg_pkg.
module ttvg_comb
	import ttvg_pkg::*;
#(
	parameter int W = 32
) (
	input  logic                      clk,
	input  logic                      en,
	input  ttvg_cfg_t                 cfg,
	input  logic signed [N_WIDTH-1:0] n1,
	input  logic signed [N_WIDTH-1:0] n2,
	input  logic signed [W-1:0]       g,
	output logic signed [W-1:0]       res
);

	localparam int MW = N_WIDTH;
	localparam int PW = MW + CFG_WIDTH;
	localparam int TW = PW + 1 - FRAC_BITS;
	localparam int VW = ((W > TW) ? W : TW) + 1;

	logic signed [MW:0] delta;
	logic [MW-1:0] mag_s1;
	logic neg_s1, neg_s2;
	logic signed [W-1:0] g_s1, g_s2, g_s3;
	logic [PW-1:0] prod_s2;
	logic [PW:0] rnd;
	logic [TW-1:0] p;
	logic signed [TW-1:0] term_s3;
	logic signed [VW-1:0] v;
	logic ovf;

	assign delta = (MW+1)'(n1) - (MW+1)'(n2);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= delta[MW] ? MW'(-delta) : MW'(delta);
			neg_s1 <= delta[MW];
			g_s1   <= g;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PW'(mag_s1) * PW'(cfg.beta);
			neg_s2  <= neg_s1;
			g_s2    <= g_s1;
		end
	end

	// round half away from zero on the magnitude
	assign rnd = {1'b0, prod_s2} + (PW+1)'(1 << (FRAC_BITS - 1));
	assign p   = rnd[PW:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			term_s3 <= neg_s2 ? -$signed(p) : $signed(p);
			g_s3    <= g_s2;
		end
	end

	assign v   = VW'(g_s3) + VW'(term_s3);
	assign ovf = (v[VW-1:W-1] != '0) && (v[VW-1:W-1] != '1);

	always_ff @(posedge clk) begin
		if (en)
			res <= ovf ? {v[VW-1], {(W-1){~v[VW-1]}}} : v[W-1:0];
	end

endmodule

>>> design/temporal_tv_gradient.sv
// Top level of the temporal TV gradient block: config registers, two
// normalizers, gradient delay line, combine stage, valid chain.
// Uses ttvg_pkg, ttvg_if, ttvg_norm, ttvg_comb.
//
//  channel | dir | beat carries
//  --------+-----+--------------------------------------------------
//  in      | in  | cur, next, prev, grad_in (real and imag)
//  out     | out | grad_out_real, grad_out_imag
//  cfg     | in  | index (0 beta, 1 beta_sq), data
//
// One beat per clock in and out while no result is stalled. The depth
// of the pipe is set mainly by the square-root pipe (one root bit per
// stage) and the 17-stage quotient pipe.
// Reset clears the valid chain and both registers; cfg is always ready.
// A stalled result freezes the whole pipe; in.ready drops only then.
module temporal_tv_gradient
	import ttvg_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	ttvg_in_if.sink   in,
	ttvg_out_if.source out,
	ttvg_cfg_if.sink  cfg
);

	localparam int W   = SAMPLE_WIDTH;
	localparam int NL  = norm_latency(W);
	localparam int LAT = NL + COMB_LATENCY;

	ttvg_cfg_t cfg_q;
	logic [LAT-1:0] vld_q;
	logic en;
	logic signed [W-1:0] gr_q [NL];
	logic signed [W-1:0] gi_q [NL];
	logic signed [N_WIDTH-1:0] n1r, n1i, n2r, n2i;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BETA:    cfg_q.beta    <= cfg.data[CFG_WIDTH-1:0];
				CFG_BETA_SQ: cfg_q.beta_sq <= cfg.data[CFG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !vld_q[LAT-1] || out.ready;
	assign in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in.valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gr_q[0] <= in.grad_in_real;
			gi_q[0] <= in.grad_in_imag;
			for (int i = 1; i < NL; i++) begin
				gr_q[i] <= gr_q[i-1];
				gi_q[i] <= gi_q[i-1];
			end
		end
	end

	ttvg_norm #(.W(W)) u_norm_fwd (
		.clk    (clk),
		.en     (en),
		.cfg    (cfg_q),
		.a_real (in.cur_real),
		.a_imag (in.cur_imag),
		.b_real (in.next_real),
		.b_imag (in.next_imag),
		.n_real (n1r),
		.n_imag (n1i)
	);

	ttvg_norm #(.W(W)) u_norm_bwd (
		.clk    (clk),
		.en     (en),
		.cfg    (cfg_q),
		.a_real (in.prev_real),
		.a_imag (in.prev_imag),
		.b_real (in.cur_real),
		.b_imag (in.cur_imag),
		.n_real (n2r),
		.n_imag (n2i)
	);

	ttvg_comb #(.W(W)) u_comb_re (
		.clk (clk),
		.en  (en),
		.cfg (cfg_q),
		.n1  (n1r),
		.n2  (n2r),
		.g   (gr_q[NL-1]),
		.res (out.grad_out_real)
	);

	ttvg_comb #(.W(W)) u_comb_im (
		.clk (clk),
		.en  (en),
		.cfg (cfg_q),
		.n1  (n1i),
		.n2  (n2i),
		.g   (gi_q[NL-1]),
		.res (out.grad_out_imag)
	);

	assign out.valid = vld_q[LAT-1];

endmodule

>>> design/ttvg_chk.sv
// Port-level checker for temporal_tv_gradient, bound to the top level.
// Uses the macros in temporal_tv_gradient_defines.svh.
`include "temporal_tv_gradient_defines.svh"

module ttvg_chk #(
	parameter int W = 32
) (
	input logic         clk,
	input logic         arst_n,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [W-1:0] out_real,
	input logic         cfg_valid,
	input logic         cfg_ready
);

	// the pipe only stops when a finished beat is stuck
	`TTVG_ASSERT_IMPLY(a_ready_free, clk, arst_n, !out_valid || out_ready, in_ready)
	`TTVG_ASSERT_IMPLY(a_cfg_open, clk, arst_n, cfg_valid, cfg_ready)
	`TTVG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`TTVG_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_real))

endmodule

bind temporal_tv_gradient ttvg_chk #(.W(SAMPLE_WIDTH)) u_ttvg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in.ready),
	.out_valid (out.valid),
	.out_ready (out.ready),
	.out_real  (out.grad_out_real),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);
